// ----- rtl/fpcd_pkg.sv -----
`default_nettype none
package fpcd_pkg;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOL  = 1'b1
  } opcode_t;

  localparam logic [7:0] LINE_END_CHAR = 8'd10;
  localparam logic [4:0] CODE_UNMAPPED = 5'd31;

  typedef struct packed {
    logic [3:0] len;
    logic [7:0] ch;
  } code_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
    logic [6:0] pending_bits;
    logic [2:0] pending_count;
  } dec_t;

  function automatic logic [4:0] map_symbol(input logic [7:0] c);
    logic [4:0] m;
    m = CODE_UNMAPPED;
    if (c >= 8'd65 && c <= 8'd90) begin
      m = 5'(c - 8'd65);
    end else begin
      case (c)
        8'd32:   m = 5'd26;
        8'd46:   m = 5'd27;
        8'd44:   m = 5'd28;
        8'd45:   m = 5'd29;
        8'd39:   m = 5'd30;
        default: m = CODE_UNMAPPED;
      endcase
    end
    return m;
  endfunction

  function automatic code_t lookup(input logic [7:0] w);
    code_t r;
    r = '{len: 4'd8, ch: 8'd63};
    unique casez (w)
      8'b101?????: r = '{len: 4'd3, ch: 8'd32};
      8'b110?????: r = '{len: 4'd3, ch: 8'd69};
      8'b111?????: r = '{len: 4'd3, ch: 8'd80};
      8'b0001????: r = '{len: 4'd4, ch: 8'd68};
      8'b0101????: r = '{len: 4'd4, ch: 8'd67};
      8'b0110????: r = '{len: 4'd4, ch: 8'd75};
      8'b0111????: r = '{len: 4'd4, ch: 8'd73};
      8'b1000????: r = '{len: 4'd4, ch: 8'd82};
      8'b00100???: r = '{len: 4'd5, ch: 8'd76};
      8'b00101???: r = '{len: 4'd5, ch: 8'd79};
      8'b00110???: r = '{len: 4'd5, ch: 8'd83};
      8'b00111???: r = '{len: 4'd5, ch: 8'd84};
      8'b01001???: r = '{len: 4'd5, ch: 8'd70};
      8'b000000??: r = '{len: 4'd6, ch: 8'd39};
      8'b000001??: r = '{len: 4'd6, ch: 8'd63};
      8'b000010??: r = '{len: 4'd6, ch: 8'd87};
      8'b000011??: r = '{len: 4'd6, ch: 8'd44};
      8'b010000??: r = '{len: 4'd6, ch: 8'd72};
      8'b010001??: r = '{len: 4'd6, ch: 8'd46};
      8'b100101??: r = '{len: 4'd6, ch: 8'd65};
      8'b10010000: r = '{len: 4'd8, ch: 8'd90};
      8'b10010001: r = '{len: 4'd8, ch: 8'd45};
      8'b10010010: r = '{len: 4'd8, ch: 8'd88};
      8'b10010011: r = '{len: 4'd8, ch: 8'd89};
      8'b10011000: r = '{len: 4'd8, ch: 8'd74};
      8'b10011001: r = '{len: 4'd8, ch: 8'd77};
      8'b10011010: r = '{len: 4'd8, ch: 8'd66};
      8'b10011011: r = '{len: 4'd8, ch: 8'd71};
      8'b10011100: r = '{len: 4'd8, ch: 8'd85};
      8'b10011101: r = '{len: 4'd8, ch: 8'd86};
      8'b10011110: r = '{len: 4'd8, ch: 8'd78};
      8'b10011111: r = '{len: 4'd8, ch: 8'd81};
      default:     r = '{len: 4'd8, ch: 8'd63};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fixed_prefix_code_decoder.sv -----
`default_nettype none
// Maps 8-bit symbols to 5-bit codes, decoded via a fixed prefix-code table.
// Each character transaction is decoded in the cycle it is accepted and
// yields zero, one or two characters; an end-of-line transaction yields one
// line-end marker and drops the leftover bits. Results leave through a
// four-entry queue at one per cycle while result_stall is low, so the block
// takes one transaction per cycle while each yields at most one result;
// the single output port sets the sustained figure at one result per
// cycle. symbol_stall rises once the queue holds more than two results.
module fixed_prefix_code_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       symbol_valid,
  output logic            symbol_stall,
  input  wire logic [0:0] opcode,
  input  wire logic [7:0] symbol,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      out_char,
  output logic            line_end,
  output logic            last
);

  localparam int DEPTH = 4;

  logic [6:0]          pending_bits;
  logic [2:0]          pending_count;
  fpcd_pkg::dec_t      dec;
  fpcd_pkg::result_t   queue [DEPTH];
  logic [1:0]          wr_ptr;
  logic [1:0]          rd_ptr;
  logic [2:0]          count;
  logic [2:0]          count_next;
  logic                push;
  logic                pop;
  logic [1:0]          push_n;

  fpcd_decode u_decode (
    .opcode        (opcode),
    .symbol        (symbol),
    .pending_bits  (pending_bits),
    .pending_count (pending_count),
    .dec           (dec)
  );

  assign symbol_stall = (count > 3'd2);
  assign push         = symbol_valid && !symbol_stall;
  assign result_valid = (count != 3'd0);
  assign pop          = result_valid && !result_stall;
  assign push_n       = push ? dec.num : 2'd0;
  assign count_next   = count + {1'b0, push_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= 7'd0;
      pending_count <= 3'd0;
      wr_ptr        <= 2'd0;
      rd_ptr        <= 2'd0;
      count         <= 3'd0;
    end else begin
      if (push) begin
        pending_bits  <= dec.pending_bits;
        pending_count <= dec.pending_count;
        wr_ptr        <= wr_ptr + push_n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_n != 2'd0) begin
      queue[wr_ptr] <= dec.r0;
    end
    if (push && push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= dec.r1;
    end
  end

  assign out_char = queue[rd_ptr].out_char;
  assign line_end = queue[rd_ptr].line_end;
  assign last     = queue[rd_ptr].last;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH))
    else $error("result queue overfilled");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (push && fpcd_pkg::opcode_t'(opcode) == fpcd_pkg::OP_EOL) |=> (pending_count == 3'd0))
    else $error("end of line left pending bits");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 3'd1))
    else $error("queue count did not drop on a lone pop");
`endif

endmodule
`default_nettype wire

// ----- rtl/fpcd_decode.sv -----
`default_nettype none
module fpcd_decode (
  input  wire logic [0:0]  opcode,
  input  wire logic [7:0]  symbol,
  input  wire logic [6:0]  pending_bits,
  input  wire logic [2:0]  pending_count,
  output fpcd_pkg::dec_t   dec
);

  logic [11:0]     full;
  logic [11:0]     aligned;
  logic [11:0]     aligned1;
  logic [3:0]      cnt;
  logic [3:0]      rem0;
  logic [3:0]      rem;
  logic            m0;
  logic            m1;
  fpcd_pkg::code_t c0;
  fpcd_pkg::code_t c1;

  always_comb begin
    full     = {pending_bits, fpcd_pkg::map_symbol(symbol)};
    cnt      = {1'b0, pending_count} + 4'd5;
    aligned  = full << (3'd7 - pending_count);
    c0       = fpcd_pkg::lookup(aligned[11:4]);
    m0       = (c0.len <= cnt);
    rem0     = cnt - c0.len;
    aligned1 = aligned << c0.len;
    c1       = fpcd_pkg::lookup(aligned1[11:4]);
    m1       = m0 && (c1.len <= rem0);
    if (m1) begin
      rem = rem0 - c1.len;
    end else if (m0) begin
      rem = rem0;
    end else begin
      rem = cnt;
    end
    if (rem > 4'd7) begin
      rem = 4'd7;
    end

    if (fpcd_pkg::opcode_t'(opcode) == fpcd_pkg::OP_EOL) begin
      dec.num           = 2'd1;
      dec.r0            = '{out_char: fpcd_pkg::LINE_END_CHAR, line_end: 1'b1, last: 1'b1};
      dec.r1            = '{out_char: fpcd_pkg::LINE_END_CHAR, line_end: 1'b1, last: 1'b1};
      dec.pending_bits  = 7'd0;
      dec.pending_count = 3'd0;
    end else begin
      dec.num           = {1'b0, m0} + {1'b0, m1};
      dec.r0            = '{out_char: c0.ch, line_end: 1'b0, last: !m1};
      dec.r1            = '{out_char: c1.ch, line_end: 1'b0, last: 1'b1};
      dec.pending_bits  = full[6:0] & ~(7'h7F << rem[2:0]);
      dec.pending_count = rem[2:0];
    end
  end

endmodule
`default_nettype wire
